FILE: rtl/rrss_pkg.sv
// Shared types and constants for the round-robin slice scheduler.
// No dependencies; imported by the ALU and the top level.
package rrss_pkg;

  localparam int OPERATION_W = 1;
  localparam int SLOT_W      = 4;
  localparam int BURST_W     = 16;
  localparam int REMAIN_W    = 16;
  localparam int ELAPSED_W   = 32;
  localparam int QUANTUM_W   = 8;
  localparam int ACTIVE_W    = 5;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [OPERATION_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OPERATION_W-1:0] OP_TICK = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_QUANTUM      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_COUNT = 1'b1;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd3;
  localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET  = 5'd3;
  localparam logic [QUANTUM_W-1:0] SLICE_MAX     = 8'hFF;

  typedef logic alu_op_t;
  localparam alu_op_t ALU_DEC      = 1'b0;
  localparam alu_op_t ALU_INC_WRAP = 1'b1;

endpackage

FILE: rtl/rrss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rrss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rrss_alu.sv
// Shared step unit: wrapped slot increment for the ready search and
// decrement of a slot's remaining time. Depends on rrss_pkg.
module rrss_alu
  import rrss_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  alu_op_t          op,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] limit,
  output logic [WIDTH-1:0] y
);

  logic [WIDTH-1:0] inc;

  assign inc = a + WIDTH'(1);

  always_comb begin
    case (op)
      ALU_INC_WRAP: y = (inc >= limit) ? '0 : inc;
      ALU_DEC:      y = a - WIDTH'(1);
      default:      y = a;
    endcase
  end

endmodule

FILE: rtl/round_robin_slice_scheduler.sv
// Round-robin time-slice scheduler: slot table, ready bits and sequencer.
// Depends on rrss_pkg, rrss_ram and rrss_alu.
//
// Input channel s_*: tuser = operation (0 load, 1 tick); tdata carries
// slot_index and burst_time. A load writes one slot and gives no result;
// it leaves the block idle, so the next item may follow directly.
// A tick gives one result on m_*: tuser = idle; tdata carries running_slot,
// remaining_after, dispatched, completed and elapsed_time.
// A tick steps through check, read, decrement and emit when the current
// slot keeps running; otherwise the search for the next ready slot runs
// between check and read, examining at most active_count slots (capped
// at MAX_SLOTS). An idle tick goes from check or the search to emit. The
// search steps one slot a cycle through the shared step unit; the slot
// table is read and written back through its RAM's read and write ports.
// s_tready is low while a tick is in progress and the next item is taken
// the cycle after the result is registered.
// cfg_* writes quantum (index 0) or active_count (index 1); always ready.
// The user is to use it only while the block is idle; the block does not enforce it.
// Reset empties the ready set, sets the current slot to the last slot and
// restores quantum 3 and active count 3. If m_tready stays low, the result
// waits in the output register and the sequencer holds before it.
module round_robin_slice_scheduler
  import rrss_pkg::*;
#(
  parameter int MAX_SLOTS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   s_tuser,   // operation
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // slot_index, burst_time
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic                   m_tuser,   // idle
  output logic [OUT_TDATA_W-1:0] m_tdata,   // running_slot, remaining_after,
                                            // dispatched, completed, elapsed_time
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int ALU_W = (TIME_BITS > CNT_W) ? TIME_BITS : CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]             state;
  logic [QUANTUM_W-1:0]   quantum;
  logic [ACTIVE_W-1:0]    active_count;
  logic [MAX_SLOTS-1:0]   ready;
  logic [SW-1:0]          cur;
  logic [SW-1:0]          scan;
  logic [CNT_W-1:0]       steps;
  logic [QUANTUM_W-1:0]   slice_used;
  logic [ELAPSED_W-1:0]   time_count;
  logic [TIME_BITS-1:0]   res_rem;
  logic                   res_idle;
  logic                   res_disp;
  logic                   res_done;

  logic [CNT_W-1:0]       count;
  logic                   in_fire;
  logic                   load_fire;
  logic [SLOT_W-1:0]      load_idx;
  logic [SW-1:0]          load_slot;
  logic                   load_in_range;
  logic [TIME_BITS-1:0]   load_time;
  logic                   cur_ok;
  logic                   next_ok;
  logic [SW-1:0]          next_slot;
  logic [CNT_W-1:0]       steps_inc;
  logic [TIME_BITS-1:0]   rem_new;
  logic                   emit_fire;
  logic [SLOT_W+REMAIN_W+1:0] res_fields;

  alu_op_t                alu_op;
  logic [ALU_W-1:0]       alu_a;
  logic [ALU_W-1:0]       alu_y;

  logic                   ram_we;
  logic [SW-1:0]          ram_waddr;
  logic [TIME_BITS-1:0]   ram_wdata;
  logic [TIME_BITS-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign load_fire = in_fire && (s_tuser == OP_LOAD);

  assign load_idx      = s_tdata[SLOT_W-1:0];
  assign load_slot     = SW'(load_idx);
  assign load_in_range = (32'(load_idx) < MAX_SLOTS);
  assign load_time     = TIME_BITS'(s_tdata[SLOT_W +: BURST_W]);

  assign count = (32'(active_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(active_count);

  assign cur_ok    = (CNT_W'(cur) < count) && ready[cur];
  assign next_slot = alu_y[SW-1:0];
  assign next_ok   = (CNT_W'(next_slot) < count) && ready[next_slot];
  assign steps_inc = steps + CNT_W'(1);
  assign rem_new   = alu_y[TIME_BITS-1:0];

  assign emit_fire  = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign res_fields = res_idle ? '0
                               : {res_done, res_disp, REMAIN_W'(res_rem), SLOT_W'(cur)};

  assign alu_op = (state == S_DEC) ? ALU_DEC : ALU_INC_WRAP;
  assign alu_a  = (state == S_DEC) ? ALU_W'(ram_rdata) : ALU_W'(scan);

  rrss_alu #(.WIDTH(ALU_W)) u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .limit (ALU_W'(count)),
    .y     (alu_y)
  );

  assign ram_we    = (load_fire && load_in_range) || (state == S_DEC);
  assign ram_waddr = (state == S_DEC) ? cur : load_slot;
  assign ram_wdata = (state == S_DEC) ? rem_new : load_time;

  rrss_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      quantum      <= QUANTUM_RESET;
      active_count <= ACTIVE_RESET;
      ready        <= '0;
      cur          <= SW'(MAX_SLOTS - 1);
      slice_used   <= QUANTUM_RESET;
      time_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUANTUM:      quantum      <= cfg_data[QUANTUM_W-1:0];
          REG_ACTIVE_COUNT: active_count <= cfg_data[ACTIVE_W-1:0];
          default:          ;
        endcase
      end
      if (emit_fire) begin
        m_tvalid <= 1'b1;
        m_tuser  <= res_idle;
        m_tdata  <= {{(OUT_TDATA_W-ELAPSED_W-SLOT_W-REMAIN_W-2){1'b0}},
                     time_count, res_fields};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load_fire && load_in_range) begin
            ready[load_slot] <= (load_time != '0);
          end
          if (in_fire && (s_tuser == OP_TICK)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_disp <= 1'b0;
          if (cur_ok && (slice_used < quantum)) begin
            res_idle <= 1'b0;
            state    <= S_READ;
          end else if (count == '0) begin
            res_idle <= 1'b1;
            state    <= S_EMIT;
          end else begin
            scan  <= cur;
            steps <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (next_ok) begin
            cur        <= next_slot;
            slice_used <= '0;
            res_disp   <= 1'b1;
            res_idle   <= 1'b0;
            state      <= S_READ;
          end else if (steps_inc == count) begin
            res_idle <= 1'b1;
            state    <= S_EMIT;
          end else begin
            scan  <= next_slot;
            steps <= steps_inc;
          end
        end
        S_READ: begin
          state <= S_DEC;
        end
        S_DEC: begin
          res_rem    <= rem_new;
          res_done   <= (rem_new == '0);
          time_count <= time_count + ELAPSED_W'(1);
          if (slice_used != SLICE_MAX) begin
            slice_used <= slice_used + QUANTUM_W'(1);
          end
          if (rem_new == '0) begin
            ready[cur] <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_load_sets_ready: assert property (@(posedge clk) disable iff (rst)
    (load_fire && load_in_range) |=> (ready[$past(load_slot)] == $past(load_time != '0)))
    else $error("load did not update ready bit");

  a_dec_slot_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC) |-> cur_ok)
    else $error("running slot not ready");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_EMIT))
    else $error("result raised outside emit");

  a_idle_result_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[21:0] == '0))
    else $error("idle result carries slot data");

  a_done_means_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser && m_tdata[21]) |-> (m_tdata[19:4] == '0))
    else $error("completed slot with time left");
`endif

endmodule

FILE: dv/tb_round_robin_slice_scheduler.sv
// Self-checking testbench for round_robin_slice_scheduler: loads and ticks with random
// gaps on both streams, results checked against an in-bench schedule predictor.
// Depends on rrss_pkg and the scheduler RTL.
module tb_round_robin_slice_scheduler
  import rrss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS  = 16;
  localparam int DRAIN_CYC  = 30;
  localparam int CYCLE_CAP  = 1000000;
  localparam int PHASE_ITEMS = 190;

  typedef struct packed {
    logic [OPERATION_W-1:0] op;
    logic [SLOT_W-1:0]      slot;
    logic [BURST_W-1:0]     burst;
  } sched_item_t;

  typedef struct packed {
    logic                 idle;
    logic [SLOT_W-1:0]    slot;
    logic [REMAIN_W-1:0]  remain;
    logic                 disp;
    logic                 done;
    logic [ELAPSED_W-1:0] elapsed;
  } sched_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic                   s_tuser = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   m_tuser;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // schedule predictor state
  logic [REMAIN_W-1:0]  slot_time [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_ready;
  logic [SLOT_W-1:0]    cur_slot;
  logic [QUANTUM_W-1:0] slice_used;
  logic [ELAPSED_W-1:0] elapsed;
  logic [QUANTUM_W-1:0] quantum_reg;
  logic [ACTIVE_W-1:0]  active_reg;

  sched_item_t   item_backlog[$];
  sched_result_t due_results[$];
  sched_item_t   drv_item;

  int  gap_left = 0;
  int  hold_left = 0;
  int  cycles = 0;
  int  errors = 0;
  int  items_sent = 0;
  int  n_ticks = 0;
  int  n_disp = 0;
  int  n_done = 0;
  int  n_idle = 0;
  int  n_settings = 1;
  bit  calm = 1'b0;

  round_robin_slice_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void advance_schedule(input sched_item_t it);
    int n;
    int s;
    int k;
    bit hit;
    sched_result_t r;
    if (it.op == OP_LOAD) begin
      slot_time[it.slot] = it.burst;
      slot_ready[it.slot] = (it.burst != '0);
      return;
    end
    n = (active_reg > NUM_SLOTS) ? NUM_SLOTS : int'(active_reg);
    hit = 1'b0;
    r = '0;
    if (int'(cur_slot) < n && slot_ready[cur_slot] && slice_used < quantum_reg) begin
      hit = 1'b1;
    end else begin
      s = int'(cur_slot);
      for (k = 0; k < n; k++) begin
        s = s + 1;
        if (s >= n) s = 0;
        if (slot_ready[s]) begin
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        cur_slot = s[SLOT_W-1:0];
        slice_used = '0;
        r.disp = 1'b1;
      end
    end
    if (!hit) begin
      r.idle = 1'b1;
      n_idle++;
    end else begin
      slot_time[cur_slot] = slot_time[cur_slot] - 1'b1;
      elapsed = elapsed + 1'b1;
      if (slice_used != SLICE_MAX) slice_used = slice_used + 1'b1;
      if (slot_time[cur_slot] == '0) begin
        r.done = 1'b1;
        slot_ready[cur_slot] = 1'b0;
      end
      r.slot = cur_slot;
      r.remain = slot_time[cur_slot];
    end
    r.elapsed = elapsed;
    n_ticks++;
    if (r.disp) n_disp++;
    if (r.done) n_done++;
    due_results.push_back(r);
  endfunction

  function automatic void flag_error(input string what, input sched_result_t want,
                                     input sched_result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t ERROR %s: exp idle=%0d slot=%0d rem=%0d disp=%0d done=%0d el=%0d",
               $time, what, want.idle, want.slot, want.remain, want.disp, want.done,
               want.elapsed);
      $display("  got idle=%0d slot=%0d rem=%0d disp=%0d done=%0d el=%0d",
               got.idle, got.slot, got.remain, got.disp, got.done, got.elapsed);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_schedule(drv_item);
        items_sent++;
        gap_left = pause_len();
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          drv_item = item_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= drv_item.op;
          s_tdata  <= {{(IN_TDATA_W-SLOT_W-BURST_W){1'b0}}, drv_item.burst, drv_item.slot};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.idle    = m_tuser;
        got.slot    = m_tdata[3:0];
        got.remain  = m_tdata[19:4];
        got.disp    = m_tdata[20];
        got.done    = m_tdata[21];
        got.elapsed = m_tdata[53:22];
        if (due_results.size() == 0) begin
          flag_error("result with nothing expected", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.idle !== want.idle || got.slot !== want.slot ||
              got.remain !== want.remain || got.disp !== want.disp ||
              got.done !== want.done || got.elapsed !== want.elapsed)
            flag_error("result mismatch", want, got);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold_left = pause_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles % 500 == 0) calm = ($urandom_range(0, 3) == 0);
  end

  initial begin
    wait (cycles >= CYCLE_CAP);
    $display("timeout after %0d cycles", cycles);
    $display("tb_round_robin_slice_scheduler: errors");
    $finish;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_QUANTUM) quantum_reg = val;
    else active_reg = val[ACTIVE_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (item_backlog.size() == 0 && !s_tvalid && due_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic void add_item(input logic [OPERATION_W-1:0] op, input int slot,
                                   input int burst);
    sched_item_t it;
    it.op = op;
    it.slot = slot[SLOT_W-1:0];
    it.burst = burst[BURST_W-1:0];
    item_backlog.push_back(it);
  endfunction

  initial begin
    int q_set [8] = '{1, 255, 0, 2, 1, 7, 16, 255};
    int a_set [8] = '{1, 16, 0, 31, 2, 5, 16, 9};
    int ph;
    int cnt;
    int n;
    int j;
    int r;
    int slot;
    int burst;

    for (j = 0; j < NUM_SLOTS; j++) slot_time[j] = '0;
    slot_ready  = '0;
    cur_slot    = SLOT_W'(NUM_SLOTS - 1);
    slice_used  = QUANTUM_RESET;
    elapsed     = '0;
    quantum_reg = QUANTUM_RESET;
    active_reg  = ACTIVE_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: idle from reset, extreme bursts, zero load, out-of-range slot,
    // completion, quantum expiry, lone ready slot, reload of the running slot
    add_item(OP_TICK, 0, 0);
    add_item(OP_LOAD, 0, 65535);
    add_item(OP_LOAD, 1, 2);
    add_item(OP_LOAD, 2, 1);
    add_item(OP_LOAD, 15, 5);
    add_item(OP_LOAD, 2, 0);
    add_item(OP_LOAD, 2, 1);
    repeat (8) add_item(OP_TICK, 9, 0);
    add_item(OP_LOAD, 0, 4);
    repeat (6) add_item(OP_TICK, 15, 65535);
    drain();

    for (ph = 0; ph < 10; ph++) begin
      if (ph < 8) begin
        write_reg(REG_QUANTUM, CFG_DATA_W'(q_set[ph]));
        write_reg(REG_ACTIVE_COUNT, CFG_DATA_W'(a_set[ph]));
      end else begin
        write_reg(REG_QUANTUM, CFG_DATA_W'($urandom_range(1, 255)));
        write_reg(REG_ACTIVE_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
      end
      n_settings++;
      n = (active_reg > NUM_SLOTS) ? NUM_SLOTS : int'(active_reg);
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          add_item(OPERATION_W'($urandom_range(0, 1)), $urandom_range(0, 15),
                   $urandom_range(0, 65535));
          cnt++;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            slot = (n > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1)
                                                       : $urandom_range(0, 15);
            r = $urandom_range(0, 99);
            if (r < 70) burst = $urandom_range(1, 6);
            else if (r < 85) burst = 0;
            else if (r < 95) burst = $urandom_range(7, 40);
            else burst = $urandom_range(0, 65535);
            add_item(OP_LOAD, slot, burst);
            cnt++;
          end
          repeat ($urandom_range(1, 12)) begin
            add_item(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 65535));
            cnt++;
          end
        end
      end
      drain();
    end

    $display("covered %0d items under %0d scheduler settings: %0d ticks, %0d dispatches,",
             items_sent, n_settings, n_ticks, n_disp);
    $display("%0d completions and %0d idle ticks; %0d failures", n_done, n_idle, errors);
    if (errors == 0 && due_results.size() == 0)
      $display("tb_round_robin_slice_scheduler: clean");
    else
      $display("tb_round_robin_slice_scheduler: errors");
    $finish;
  end

endmodule
